FILE: rtl/core/rfa_pkg.sv
// Package for the reduced fraction ALU: request, status and order codes,
// saturation limits and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package rfa_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DEN_ZERO = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    localparam logic [1:0] ORD_LT = 2'b11;
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_GT = 2'b01;

    localparam logic [63:0] NUM_MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] DEN_MAX     = 64'h3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_MUL  = 7'b000_0010,
        S_SUM  = 7'b000_0100,
        S_TWOS = 7'b000_1000,
        S_GCD  = 7'b001_0000,
        S_DIV  = 7'b010_0000,
        S_DONE = 7'b100_0000
    } state_t;

endpackage

FILE: rtl/core/reduced_fraction_alu.sv
// Top level of the reduced fraction ALU: sequencer around one shared multiplier,
// a binary GCD loop and a restoring divider. Depends on rfa_pkg.
//
// Sequence: error and unknown requests go straight to the done state; compare
// passes through the multiply and sum states; the other operations add the GCD
// steps (one shift or subtract each) and two exact 64-step divisions.
// One item at a time: the next is taken once the current result is handed to
// the output register. Reset (rst_n, asynchronous) returns to idle, output empty.
`timescale 1ns / 1ps

module reduced_fraction_alu
    import rfa_pkg::*;
#(
    parameter int OPERAND_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic        [2:0]  req_type,
    input  logic signed [31:0] a_num,
    input  logic signed [31:0] a_den,
    input  logic signed [31:0] b_num,
    input  logic signed [31:0] b_den,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [63:0] res_num,
    output logic        [61:0] res_den,
    output logic signed [1:0]  order,
    output logic        [1:0]  status
);

    localparam int W = OPERAND_WIDTH;

    state_t         state_reg;
    logic [2:0]     op_reg;
    logic [W-1:0]   an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic           a_neg_reg, b_neg_reg;
    logic [1:0]     mcnt_reg;
    logic [63:0]    p0_reg, p1_reg, p2_reg;
    logic [63:0]    nm_reg, dm_reg;
    logic           neg_reg;
    logic [1:0]     ord_reg, stat_reg;
    logic [63:0]    gx_reg, gy_reg, gcd_reg;
    logic [5:0]     gk_reg;
    logic [63:0]    rem_reg, quo_reg;
    logic [5:0]     dcnt_reg;
    logic           dsel_reg;
    logic           out_valid_reg;
    logic [63:0]    out_num_reg;
    logic [61:0]    out_den_reg;
    logic [1:0]     out_ord_reg, out_stat_reg;

    // operand magnitudes and signs
    logic [W-1:0] an_lo, ad_lo, bn_lo, bd_lo;
    logic [W-1:0] an_mag, ad_mag, bn_mag, bd_mag;
    assign an_lo  = a_num[W-1:0];
    assign ad_lo  = a_den[W-1:0];
    assign bn_lo  = b_num[W-1:0];
    assign bd_lo  = b_den[W-1:0];
    assign an_mag = an_lo[W-1] ? (~an_lo + 1'b1) : an_lo;
    assign ad_mag = ad_lo[W-1] ? (~ad_lo + 1'b1) : ad_lo;
    assign bn_mag = bn_lo[W-1] ? (~bn_lo + 1'b1) : bn_lo;
    assign bd_mag = bd_lo[W-1] ? (~bd_lo + 1'b1) : bd_lo;

    logic req_fire;
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;

    // shared multiplier
    logic [W-1:0]   mul_a, mul_b;
    logic [2*W-1:0] mul_p;
    always_comb
    begin
        case (mcnt_reg)
            2'd0:    begin mul_a = an_mag_reg;
                           mul_b = (op_reg == OP_MUL) ? bn_mag_reg : bd_mag_reg; end
            2'd1:    begin mul_a = bn_mag_reg; mul_b = ad_mag_reg; end
            default: begin mul_a = ad_mag_reg; mul_b = bd_mag_reg; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // combine products
    logic        t1_neg, t2_neg, sum_neg;
    logic [63:0] sum_mag, diff01, diff10;
    logic        m0_ge_m1;
    logic signed [64:0] lval, rval;
    always_comb
    begin
        t1_neg   = a_neg_reg;
        t2_neg   = (op_reg == OP_SUB) ? !b_neg_reg : b_neg_reg;
        m0_ge_m1 = (p0_reg >= p1_reg);
        diff01   = p0_reg - p1_reg;
        diff10   = p1_reg - p0_reg;
        if (t1_neg == t2_neg)
        begin
            sum_mag = p0_reg + p1_reg;
            sum_neg = t1_neg;
        end
        else if (m0_ge_m1)
        begin
            sum_mag = diff01;
            sum_neg = t1_neg;
        end
        else
        begin
            sum_mag = diff10;
            sum_neg = t2_neg;
        end
        lval = a_neg_reg ? (65'sd0 - $signed({1'b0, p0_reg})) : $signed({1'b0, p0_reg});
        rval = b_neg_reg ? (65'sd0 - $signed({1'b0, p1_reg})) : $signed({1'b0, p1_reg});
    end

    logic [63:0] c_nm, c_dm;
    logic        c_neg;
    always_comb
    begin
        unique case (op_reg)
            OP_MUL:  begin c_nm = p0_reg;  c_dm = p2_reg; c_neg = a_neg_reg ^ b_neg_reg; end
            OP_DIV:  begin c_nm = p0_reg;  c_dm = p1_reg; c_neg = a_neg_reg ^ b_neg_reg; end
            default: begin c_nm = sum_mag; c_dm = p2_reg; c_neg = sum_neg; end
        endcase
    end

    // divider step
    logic [64:0] div_sh, div_sub;
    logic        div_ge;
    logic [63:0] rem_step, quo_step;
    assign div_sh   = {rem_reg, quo_reg[63]};
    assign div_sub  = div_sh - {1'b0, gcd_reg};
    assign div_ge   = (div_sh >= {1'b0, gcd_reg});
    assign rem_step = div_ge ? div_sub[63:0] : div_sh[63:0];
    assign quo_step = {quo_reg[62:0], div_ge};

    // saturated outputs
    logic [63:0] sat_nm, sat_dm;
    assign sat_nm = (nm_reg > NUM_MAG_MAX) ? NUM_MAG_MAX : nm_reg;
    assign sat_dm = (dm_reg > DEN_MAX) ? DEN_MAX : dm_reg;

    logic out_free;
    assign out_free = !out_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mcnt_reg      <= 2'd0;
            dcnt_reg      <= 6'd0;
            dsel_reg      <= 1'b0;
            gk_reg        <= 6'd0;
        end
        else
        begin
            // in S_DONE the output register is loaded below instead
            if (out_valid_reg && res_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        op_reg     <= req_type;
                        an_mag_reg <= an_mag;
                        ad_mag_reg <= ad_mag;
                        bn_mag_reg <= bn_mag;
                        bd_mag_reg <= bd_mag;
                        a_neg_reg  <= an_lo[W-1] ^ ad_lo[W-1];
                        b_neg_reg  <= bn_lo[W-1] ^ bd_lo[W-1];
                        nm_reg     <= 64'd0;
                        dm_reg     <= 64'd1;
                        neg_reg    <= 1'b0;
                        ord_reg    <= ORD_EQ;
                        mcnt_reg   <= 2'd0;
                        if (ad_lo == '0 || bd_lo == '0)
                        begin
                            stat_reg  <= ST_DEN_ZERO;
                            state_reg <= S_DONE;
                        end
                        else if (req_type == OP_DIV && bn_lo == '0)
                        begin
                            stat_reg  <= ST_DIV_ZERO;
                            state_reg <= S_DONE;
                        end
                        else if (req_type > OP_CMP)
                        begin
                            stat_reg  <= ST_OK;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            stat_reg  <= ST_OK;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    case (mcnt_reg)
                        2'd0:    p0_reg <= 64'(mul_p);
                        2'd1:    p1_reg <= 64'(mul_p);
                        default: p2_reg <= 64'(mul_p);
                    endcase
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd2)
                        state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (op_reg == OP_CMP)
                    begin
                        ord_reg   <= (lval < rval) ? ORD_LT : ((lval > rval) ? ORD_GT : ORD_EQ);
                        state_reg <= S_DONE;
                    end
                    else if (c_nm == 64'd0)
                        state_reg <= S_DONE;
                    else
                    begin
                        nm_reg    <= c_nm;
                        dm_reg    <= c_dm;
                        neg_reg   <= c_neg;
                        gx_reg    <= c_nm;
                        gy_reg    <= c_dm;
                        gk_reg    <= 6'd0;
                        state_reg <= S_TWOS;
                    end
                end
                S_TWOS:
                begin
                    // strip common factors of two
                    if (!gx_reg[0] && !gy_reg[0])
                    begin
                        gx_reg <= gx_reg >> 1;
                        gy_reg <= gy_reg >> 1;
                        gk_reg <= gk_reg + 6'd1;
                    end
                    else
                        state_reg <= S_GCD;
                end
                S_GCD:
                begin
                    if (gx_reg == gy_reg)
                    begin
                        gcd_reg   <= gx_reg << gk_reg;
                        rem_reg   <= 64'd0;
                        quo_reg   <= nm_reg;
                        dcnt_reg  <= 6'd0;
                        dsel_reg  <= 1'b0;
                        state_reg <= S_DIV;
                    end
                    else if (!gx_reg[0])
                        gx_reg <= gx_reg >> 1;
                    else if (!gy_reg[0])
                        gy_reg <= gy_reg >> 1;
                    else if (gx_reg > gy_reg)
                        gx_reg <= (gx_reg - gy_reg) >> 1;
                    else
                        gy_reg <= (gy_reg - gx_reg) >> 1;
                end
                S_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 6'd1;
                    if (dcnt_reg == 6'd63 && !dsel_reg)
                    begin
                        // numerator done: start on the denominator
                        nm_reg   <= quo_step;
                        rem_reg  <= 64'd0;
                        quo_reg  <= dm_reg;
                        dsel_reg <= 1'b1;
                    end
                    else
                    begin
                        rem_reg <= rem_step;
                        quo_reg <= quo_step;
                        if (dcnt_reg == 6'd63)
                        begin
                            dm_reg    <= quo_step;
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_num_reg   <= neg_reg ? (64'd0 - sat_nm) : sat_nm;
                        out_den_reg   <= sat_dm[61:0];
                        out_ord_reg   <= ord_reg;
                        out_stat_reg  <= stat_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign res_valid = out_valid_reg;
    assign res_num   = $signed(out_num_reg);
    assign res_den   = out_den_reg;
    assign order     = $signed(out_ord_reg);
    assign status    = out_stat_reg;

endmodule

FILE: tb/reduced_fraction_alu_test.sv
// Self-checking testbench for reduced_fraction_alu: a queue-fed driver, a monitor
// and an internal fraction predictor, checked item by item. Depends on rfa_pkg.
`timescale 1ns / 1ps

module reduced_fraction_alu_test;
    import rfa_pkg::*;

    localparam logic [2:0] OP_UNKNOWN_LO = OP_CMP + 3'd1;
    localparam int         IDLE_TAIL     = 100;
    localparam int         STALL_LIMIT   = 5000;
    localparam int         HOLDOFF_LEN   = 600;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] an;
        logic signed [31:0] ad;
        logic signed [31:0] bn;
        logic signed [31:0] bd;
        bit                 drain_first;
    } fraction_req_t;

    typedef struct {
        logic signed [63:0] num;
        logic [61:0]        den;
        logic [1:0]         ord;
        logic [1:0]         st;
    } fraction_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    logic [2:0]         req_type = OP_ADD;
    logic signed [31:0] a_num = '0;
    logic signed [31:0] a_den = 32'sd1;
    logic signed [31:0] b_num = '0;
    logic signed [31:0] b_den = 32'sd1;
    logic               res_valid;
    logic               res_ready = 1'b0;
    logic signed [63:0] res_num;
    logic [61:0]        res_den;
    logic signed [1:0]  order;
    logic [1:0]         status;

    fraction_req_t pending_reqs[$];
    fraction_res_t expected_fracs[$];
    fraction_req_t current_req;
    int            error_count = 0;
    int            sent_count = 0;
    int            send_gap = 0;
    int            recv_stall = 0;
    int            holdoff_left = 0;
    bit            holdoff_done = 0;
    int            quiet_cycles = 0;
    bit            next_valid;

    reduced_fraction_alu uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .res_valid(res_valid), .res_ready(res_ready),
        .res_num(res_num), .res_den(res_den), .order(order), .status(status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // signed sum of two cross terms as sign and magnitude
    function automatic void sum_terms(input logic signed [63:0] x, input logic signed [63:0] y,
                                      output bit neg, output logic [63:0] mag);
        logic signed [63:0] s;
        if (x < 0 && y < 0)
        begin
            neg = 1;
            mag = 64'(-x) + 64'(-y);
        end
        else if (x >= 0 && y >= 0)
        begin
            neg = 0;
            mag = 64'(x) + 64'(y);
        end
        else
        begin
            s = x + y;
            neg = s < 0;
            mag = s < 0 ? 64'(-s) : 64'(s);
        end
    endfunction

    function automatic fraction_res_t reduce_fraction(fraction_req_t r);
        fraction_res_t      res;
        logic signed [63:0] an, ad, bn, bd, p, q;
        logic [63:0]        nm, dm, x, y, t;
        bit                 neg, have;
        an = r.an; ad = r.ad; bn = r.bn; bd = r.bd;
        res.num = 0; res.den = 1; res.ord = ORD_EQ; res.st = ST_OK;
        neg = 0; nm = 0; dm = 1; have = 1;
        if (ad == 0 || bd == 0)
        begin
            res.st = ST_DEN_ZERO;
            return res;
        end
        if (ad < 0)
        begin
            ad = -ad; an = -an;
        end
        if (bd < 0)
        begin
            bd = -bd; bn = -bn;
        end
        case (r.op)
            OP_ADD: begin sum_terms(an * bd, bn * ad, neg, nm); dm = ad * bd; end
            OP_SUB: begin sum_terms(an * bd, -(bn * ad), neg, nm); dm = ad * bd; end
            OP_MUL:
            begin
                p = an * bn;
                neg = p < 0;
                nm = p < 0 ? 64'(-p) : 64'(p);
                dm = ad * bd;
            end
            OP_DIV:
            begin
                if (bn == 0)
                begin
                    res.st = ST_DIV_ZERO;
                    have = 0;
                end
                else
                begin
                    p = an * bd;
                    q = ad * bn;
                    neg = (p < 0) != (q < 0);
                    nm = p < 0 ? 64'(-p) : 64'(p);
                    dm = q < 0 ? 64'(-q) : 64'(q);
                end
            end
            OP_CMP:
            begin
                p = an * bd;
                q = bn * ad;
                res.ord = p < q ? ORD_LT : (p > q ? ORD_GT : ORD_EQ);
                have = 0;
            end
            default: have = 0;
        endcase
        if (!have)
            return res;
        if (nm == 0)
        begin
            dm = 1;
            neg = 0;
        end
        else
        begin
            x = nm; y = dm;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            nm = nm / x;
            dm = dm / x;
        end
        if (nm > NUM_MAG_MAX) nm = NUM_MAG_MAX;
        if (dm > DEN_MAX) dm = DEN_MAX;
        res.num = neg ? -nm : nm;
        res.den = dm[61:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 11))
            0: return 32'sd0;
            1: return 32'sd1;
            2: return -32'sd1;
            3: return 32'sh7FFF_FFFF;
            4: return 32'sh8000_0000;
            5: return 32'sh8000_0001;
            6, 7, 8: return $signed(32'($urandom_range(0, 40))) - 32'sd20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_den();
        logic signed [31:0] v;
        if ($urandom_range(0, 29) == 0)
            return 32'sd0;
        v = pick_operand();
        return v == 0 ? 32'sd1 : v;
    endfunction

    task automatic queue_req(logic [2:0] op, logic signed [31:0] an, logic signed [31:0] ad,
                             logic signed [31:0] bn, logic signed [31:0] bd, bit drain);
        fraction_req_t r;
        r.op = op; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd; r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    // driver: hold each item until it is accepted, then maybe idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            next_valid = req_valid;
            if (req_valid && req_ready)
            begin
                expected_fracs.push_back(reduce_fraction(current_req));
                sent_count++;
                next_valid = 0;
                if (pending_reqs.size() > IDLE_TAIL && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 8);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain_first && expected_fracs.size() != 0))
                begin
                    current_req = pending_reqs.pop_front();
                    req_type <= current_req.op;
                    a_num <= current_req.an;
                    a_den <= current_req.ad;
                    b_num <= current_req.bn;
                    b_den <= current_req.bd;
                    next_valid = 1;
                end
            end
            req_valid <= next_valid;
        end
    end

    // monitor: check each result item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (expected_fracs.size() == 0)
                begin
                    $display("unexpected result item at %0t", $realtime);
                    error_count++;
                end
                else
                begin
                    if (res_num !== expected_fracs[0].num)
                        report_mismatch("res_num", res_num, expected_fracs[0].num);
                    if (res_den !== expected_fracs[0].den)
                        report_mismatch("res_den", res_den, expected_fracs[0].den);
                    if (order !== expected_fracs[0].ord)
                        report_mismatch("order", order, expected_fracs[0].ord);
                    if (status !== expected_fracs[0].st)
                        report_mismatch("status", status, expected_fracs[0].st);
                    void'(expected_fracs.pop_front());
                end
            end
            if (!holdoff_done && sent_count >= 300)
            begin
                holdoff_done = 1;
                holdoff_left = HOLDOFF_LEN;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                res_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (pending_reqs.size() > IDLE_TAIL && $urandom_range(0, 4) == 0)
                    recv_stall = $urandom_range(1, 8);
            end
        end
    end

    // watchdog: give up when nothing moves for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("reduced_fraction_alu_test failed");
            $finish;
        end
    end

    initial
    begin
        // directed: extremes, every operation, each error path
        queue_req(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3, 0);
        queue_req(OP_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2, 0);
        queue_req(OP_MUL, -32'sd3, 32'sd4, 32'sd2, -32'sd9, 0);
        queue_req(OP_DIV, 32'sd5, -32'sd6, -32'sd10, 32'sd3, 0);
        queue_req(OP_CMP, 32'sd1, 32'sd3, 32'sd1, 32'sd2, 0);
        queue_req(OP_CMP, 32'sd2, 32'sd4, -32'sd1, -32'sd2, 0);
        queue_req(OP_CMP, 32'sd3, 32'sd2, 32'sd1, 32'sd1, 0);
        queue_req(OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1, 0);
        queue_req(OP_CMP, 32'sd1, 32'sd1, 32'sd1, 32'sd0, 0);
        queue_req(OP_DIV, 32'sd1, 32'sd0, 32'sd0, 32'sd1, 0);
        queue_req(OP_DIV, 32'sd7, 32'sd3, 32'sd0, -32'sd5, 0);
        queue_req(OP_UNKNOWN_LO, 32'sd7, 32'sd3, 32'sd2, 32'sd5, 0);
        queue_req(3'b111, 32'sh8000_0000, 32'sd0, 32'sd2, 32'sd5, 0);
        queue_req(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sd1, 0);
        queue_req(OP_MUL, 32'sh8000_0000, 32'sd1, 32'sh8000_0000, 32'sd1, 0);
        queue_req(OP_DIV, 32'sh8000_0000, 32'sd1, 32'sd1, 32'sh8000_0000, 0);
        queue_req(OP_ADD, 32'sh8000_0000, 32'sd1, 32'sh8000_0000, 32'sd1, 0);
        queue_req(OP_SUB, 32'sh7FFF_FFFF, 32'sh8000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        queue_req(OP_ADD, 32'sd0, -32'sd7, 32'sd0, 32'sd5, 0);
        queue_req(OP_DIV, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 32'sh7FFF_FFFD, 32'sh7FFF_FFFF, 0);
        queue_req(OP_CMP, 32'sh8000_0000, 32'sd1, 32'sh7FFF_FFFF, 32'sd1, 0);
        for (int i = 0; i < 750; i++)
            queue_req($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7)) :
                      3'($urandom_range(0, 4)),
                      pick_operand(), pick_den(), pick_operand(), pick_den(), i == 450);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !req_valid && expected_fracs.size() == 0);
        repeat (300) @(posedge clk);
        if (error_count == 0)
            $display("reduced_fraction_alu_test passed");
        else
            $display("reduced_fraction_alu_test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/rfa_pkg.sv
rtl/core/reduced_fraction_alu.sv
tb/reduced_fraction_alu_test.sv
